FILE: hdl/dbp_pkg.sv
// Shared types and constants for the spectrum bin dB smoothing / peak-hold block.
// Used by every module under hdl/; depends on nothing.
package dbp_pkg;

   localparam int BIN_W          = 11;
   localparam int MAG_W          = 32;
   localparam int LVL_W          = 16;
   localparam int LOG_W          = 21;   // unsigned Q5.16 log2 result
   localparam int LOG_LAT        = 18;   // two normalize stages + 16 squaring stages
   localparam int QUEUE_DEPTH    = 4;
   localparam int QA_W           = 2;
   localparam int DEF_MAX_BINS   = 2048;
   localparam int DEF_DB_FRAC    = 8;

   localparam logic signed [23:0] LOG2_FLOOR_Q16 = -24'sd1306235;
   localparam logic signed [47:0] DB_PER_LOG2_Q16 = 48'sd394566;
   localparam logic signed [23:0] MAG_OFF_11 = 24'sd1966080;           // 30 * 2^16
   localparam logic signed [23:0] MAG_OFF_12 = 24'sd2031616;           // 31 * 2^16
   localparam logic signed [23:0] TILT_OFF_11 = 24'sd1374014;          // 11*2^16 + log2(1000)
   localparam logic signed [23:0] TILT_OFF_12 = 24'sd1439550;          // 12*2^16 + log2(1000)

   // Register map indexes
   localparam logic [2:0] REG_FFT_ORDER    = 3'd0;
   localparam logic [2:0] REG_SAMPLE_RATE  = 3'd1;
   localparam logic [2:0] REG_TILT_SLOPE   = 3'd2;
   localparam logic [2:0] REG_SMOOTH_COEFF = 3'd3;
   localparam logic [2:0] REG_FLOOR_DB     = 3'd4;
   localparam logic [2:0] REG_CEILING_DB   = 3'd5;
   localparam logic [2:0] REG_PEAK_DECAY   = 3'd6;

   localparam logic [3:0]  RST_FFT_ORDER    = 4'd11;
   localparam logic [17:0] RST_SAMPLE_RATE  = 18'd44100;
   localparam logic [11:0] RST_TILT_SLOPE   = 12'd0;
   localparam logic [15:0] RST_SMOOTH_COEFF = 16'd26214;
   localparam logic [15:0] RST_FLOOR_DB     = 16'hA600;   // -90 dB
   localparam logic [15:0] RST_CEILING_DB   = 16'h0600;   // +6 dB
   localparam logic [11:0] RST_PEAK_DECAY   = 12'd128;

   typedef struct packed {
      logic               order12;
      logic [17:0]        sample_rate;
      logic [11:0]        tilt_slope;
      logic signed [15:0] floor_db;
      logic signed [15:0] ceiling_db;
   } front_cfg_type;

   typedef struct packed {
      logic [15:0]        smooth_coeff;
      logic signed [15:0] floor_db;
      logic [11:0]        peak_decay;
   } back_cfg_type;

   typedef struct packed {
      logic [BIN_W-1:0]       bin;
      logic signed [LVL_W-1:0] level;
      logic                   last;
   } q_item_type;

endpackage

FILE: hdl/dbp_log2.sv
// Pipelined base-2 logarithm, Q5.16 result, truncating repeated-squaring method.
// Depends on dbp_pkg. Takes one operand per cycle while en is high.
module dbp_log2 (
   input  logic                  clock,
   input  logic                  en,
   input  logic [dbp_pkg::MAG_W-1:0] x,
   output logic [dbp_pkg::LOG_W-1:0] y
);
   import dbp_pkg::*;

   logic [31:0] xa_ff;
   logic [4:0]  msb_in;
   logic [4:0]  pa_ff;
   logic [4:0]  p_st   [0:16];
   logic [31:0] m_st   [0:16];
   logic [15:0] f_st   [0:16];

   // top set bit
   always_comb begin
      msb_in = '0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) msb_in = 5'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xa_ff   <= x;
         pa_ff   <= msb_in;
         m_st[0] <= xa_ff << (5'd31 - pa_ff);
         p_st[0] <= pa_ff;
         f_st[0] <= '0;
      end
   end

   for (genvar k = 0; k < 16; k++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] t;
      assign sq = 64'(m_st[k]) * 64'(m_st[k]);
      assign t  = sq[63:31];
      always_ff @(posedge clock) begin
         if (en) begin
            m_st[k+1] <= t[32] ? t[32:1] : t[31:0];
            f_st[k+1] <= {f_st[k][14:0], t[32]};
            p_st[k+1] <= p_st[k];
         end
      end
   end

   assign y = {p_st[16], f_st[16]};

endmodule

FILE: hdl/dbp_front.sv
// Front part: magnitude and tilt logarithms, dB scaling, tilt and clamping.
// Depends on dbp_pkg and dbp_log2. Pushes one level per cycle unless q_full.
module dbp_front #(
   parameter int DB_FRAC_BITS = dbp_pkg::DEF_DB_FRAC
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [dbp_pkg::BIN_W-1:0]   in_bin,
   input  logic [dbp_pkg::MAG_W-1:0]   in_mag,
   input  logic                        block_in,
   input  dbp_pkg::front_cfg_type     cfg,
   input  logic                        q_full,
   output logic                        q_push,
   output dbp_pkg::q_item_type         q_item
);
   import dbp_pkg::*;

   localparam int SH_DB = 32 - DB_FRAC_BITS;
   localparam int SH_T  = 24 - DB_FRAC_BITS;

   logic en;
   logic accept;

   logic             v0_ff;
   logic [BIN_W-1:0] bin0_ff;
   logic [31:0]      mag0_ff;
   logic [31:0]      prod0_ff;

   logic [LOG_W-1:0] lm;
   logic [LOG_W-1:0] lp;

   logic [LOG_LAT-1:0] v_line_ff;
   logic [LOG_LAT-1:0] magz_line_ff;
   logic [LOG_LAT-1:0] prodz_line_ff;
   logic [BIN_W-1:0]   bin_line_ff [0:LOG_LAT-1];

   logic                va_ff, vb_ff, vc_ff;
   logic [BIN_W-1:0]    bina_ff, binb_ff;
   logic                nza_ff, nzb_ff;
   logic signed [23:0]  lg_in, lg_ff;
   logic signed [23:0]  t_in, t_ff;
   logic signed [47:0]  pm_ff;
   logic signed [39:0]  pt_ff;
   logic signed [47:0]  rdb;
   logic signed [39:0]  rt;
   logic signed [23:0]  db_sum, db_lo, db_cl;
   logic [BIN_W-1:0]    last_idx;
   q_item_type          item_ff;

   assign en       = !(vc_ff && q_full);
   assign in_ready = en && !block_in;
   assign accept   = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bin0_ff  <= in_bin;
         mag0_ff  <= in_mag;
         prod0_ff <= 32'(in_bin) * 32'(cfg.sample_rate);
      end
   end

   dbp_log2 u_log_mag (.clock(clock), .en(en), .x(mag0_ff),  .y(lm));
   dbp_log2 u_log_frq (.clock(clock), .en(en), .x(prod0_ff), .y(lp));

   // sideband travels with the log pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v_line_ff <= '0;
      end else if (en) begin
         v_line_ff <= {v_line_ff[LOG_LAT-2:0], v0_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         magz_line_ff  <= {magz_line_ff[LOG_LAT-2:0], (mag0_ff == '0)};
         prodz_line_ff <= {prodz_line_ff[LOG_LAT-2:0], (prod0_ff == '0)};
         bin_line_ff[0] <= bin0_ff;
         for (int i = 1; i < LOG_LAT; i++) begin
            bin_line_ff[i] <= bin_line_ff[i-1];
         end
      end
   end

   always_comb begin
      lg_in = $signed({3'b000, lm}) - (cfg.order12 ? MAG_OFF_12 : MAG_OFF_11);
      if (magz_line_ff[LOG_LAT-1] || (lg_in < LOG2_FLOOR_Q16)) begin
         lg_in = LOG2_FLOOR_Q16;
      end
      t_in = (prodz_line_ff[LOG_LAT-1] ? 24'sd0 : $signed({3'b000, lp}))
             - (cfg.order12 ? TILT_OFF_12 : TILT_OFF_11);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= v_line_ff[LOG_LAT-1];
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_comb begin
      rdb    = (pm_ff + (48'sd1 <<< (SH_DB - 1))) >>> SH_DB;
      rt     = (pt_ff + (40'sd1 <<< (SH_T - 1))) >>> SH_T;
      db_sum = 24'(rdb) + 24'(rt);
      db_lo  = (db_sum < 24'(cfg.floor_db)) ? 24'(cfg.floor_db) : db_sum;
      db_cl  = (db_lo > 24'(cfg.ceiling_db)) ? 24'(cfg.ceiling_db) : db_lo;
      last_idx = cfg.order12 ? BIN_W'(2047) : BIN_W'(1023);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bina_ff <= bin_line_ff[LOG_LAT-1];
         nza_ff  <= (bin_line_ff[LOG_LAT-1] != '0);
         lg_ff   <= lg_in;
         t_ff    <= t_in;
         binb_ff <= bina_ff;
         nzb_ff  <= nza_ff;
         pm_ff   <= 48'(lg_ff) * DB_PER_LOG2_Q16;
         pt_ff   <= nza_ff ? 40'(t_ff) * $signed(40'(cfg.tilt_slope)) : 40'sd0;
         item_ff.bin   <= binb_ff;
         item_ff.level <= db_cl[LVL_W-1:0];
         item_ff.last  <= (binb_ff == last_idx);
      end
   end

   assign q_push = vc_ff && !q_full;
   assign q_item = item_ff;

endmodule

FILE: hdl/dbp_queue.sv
// Short FIFO between the front and back parts.
// Depends on dbp_pkg for the item type and depth.
module dbp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dbp_pkg::q_item_type din,
   output logic                full,
   input  logic                pop,
   output logic                nonempty,
   output dbp_pkg::q_item_type dout
);
   import dbp_pkg::*;

   q_item_type      slot_ff [0:QUEUE_DEPTH-1];
   logic [QA_W-1:0] wr_ff, rd_ff;
   logic [QA_W:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == (QA_W+1)'(QUEUE_DEPTH));
   assign nonempty = (cnt_ff != '0);
   assign dout     = slot_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= din;
   end

endmodule

FILE: hdl/dbp_back.sv
// Back part: per-bin smoothing and peak-hold memory, update and result register.
// Depends on dbp_pkg. Holds the store memory and its clearing pass.
module dbp_back #(
   parameter int MAX_BINS = dbp_pkg::DEF_MAX_BINS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  dbp_pkg::q_item_type        q_item,
   output logic                       q_pop,
   input  dbp_pkg::back_cfg_type      cfg,
   input  logic                       fill_start,
   output logic                       clearing,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [dbp_pkg::BIN_W-1:0]  out_bin,
   output logic [dbp_pkg::LVL_W-1:0]  out_level,
   output logic [dbp_pkg::LVL_W-1:0]  out_smooth,
   output logic [dbp_pkg::LVL_W-1:0]  out_peak,
   output logic                       out_last
);
   import dbp_pkg::*;

   localparam int AW = $clog2(MAX_BINS);
   localparam int EW = BIN_W + AW;

   logic [2*LVL_W-1:0] mem [0:MAX_BINS-1];
   logic [2*LVL_W-1:0] rd_ff;

   logic          clr_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic [15:0]   fill_ff;

   logic [EW-1:0] qbin_ext;
   logic [EW-1:0] ebin_ext;

   logic                    e_valid_ff;
   logic [BIN_W-1:0]        e_bin_ff;
   logic signed [LVL_W-1:0] e_lvl_ff;
   logic                    e_last_ff;
   logic                    e_fwd_ff;
   logic                    e_adv;
   logic                    e_in;
   logic                    e_wr;
   logic                    fwd_in;

   logic signed [LVL_W-1:0] lw_s_ff, lw_p_ff;
   logic signed [LVL_W-1:0] s_old, p_old, s_new, p_new;
   logic signed [16:0]      diff;
   logic signed [33:0]      mprod;
   logic signed [33:0]      adj;
   logic signed [17:0]      s_sum;
   logic signed [16:0]      lowered;

   logic                    rsp_v_ff;
   logic [BIN_W-1:0]        rsp_bin_ff;
   logic [LVL_W-1:0]        rsp_lvl_ff, rsp_s_ff, rsp_p_ff;
   logic                    rsp_last_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [2*LVL_W-1:0] wr_data;

   assign clearing = clr_ff;
   assign qbin_ext = EW'(q_item.bin);
   assign ebin_ext = EW'(e_bin_ff);
   assign e_in     = ebin_ext < EW'(MAX_BINS);
   assign e_adv    = e_valid_ff && (!rsp_v_ff || out_ready);
   assign e_wr     = e_adv && e_in;
   assign q_pop    = q_valid && !clr_ff && (!e_valid_ff || e_adv);
   assign fwd_in   = e_wr && (e_bin_ff == q_item.bin);

   // clearing pass after reset and after every order write
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         fill_ff    <= RST_FLOOR_DB;
      end else if (fill_start) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         fill_ff    <= cfg.floor_db;
      end else if (clr_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(MAX_BINS - 1)) clr_ff <= 1'b0;
      end
   end

   always_comb begin
      wr_en   = clr_ff || e_wr;
      wr_addr = clr_ff ? clr_cnt_ff : ebin_ext[AW-1:0];
      wr_data = clr_ff ? {fill_ff, fill_ff} : {s_new, p_new};
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (q_pop) rd_ff <= mem[qbin_ext[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (q_pop) begin
         e_valid_ff <= 1'b1;
      end else if (e_adv) begin
         e_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         e_bin_ff  <= q_item.bin;
         e_lvl_ff  <= q_item.level;
         e_last_ff <= q_item.last;
         e_fwd_ff  <= fwd_in;
      end
      if (e_wr) begin
         lw_s_ff <= s_new;
         lw_p_ff <= p_new;
      end
   end

   // one-pole smoothing and peak hold
   always_comb begin
      if (e_fwd_ff) begin
         s_old = lw_s_ff;
         p_old = lw_p_ff;
      end else if (e_in) begin
         s_old = rd_ff[2*LVL_W-1:LVL_W];
         p_old = rd_ff[LVL_W-1:0];
      end else begin
         s_old = cfg.floor_db;
         p_old = cfg.floor_db;
      end
      diff  = 17'(e_lvl_ff) - 17'(s_old);
      mprod = 34'(diff) * $signed(34'(cfg.smooth_coeff));
      adj   = (mprod + 34'sd32768) >>> 16;
      s_sum = 18'(s_old) + 18'(adj);
      s_new = s_sum[LVL_W-1:0];
      lowered = 17'(p_old) - $signed(17'(cfg.peak_decay));
      if (s_new > p_old) begin
         p_new = s_new;
      end else if (lowered > 17'(cfg.floor_db)) begin
         p_new = lowered[LVL_W-1:0];
      end else begin
         p_new = cfg.floor_db;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (e_adv) begin
         rsp_v_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (e_adv) begin
         rsp_bin_ff  <= e_bin_ff;
         rsp_lvl_ff  <= e_lvl_ff;
         rsp_s_ff    <= s_new;
         rsp_p_ff    <= p_new;
         rsp_last_ff <= e_last_ff;
      end
   end

   assign out_valid  = rsp_v_ff;
   assign out_bin    = rsp_bin_ff;
   assign out_level  = rsp_lvl_ff;
   assign out_smooth = rsp_s_ff;
   assign out_peak   = rsp_p_ff;
   assign out_last   = rsp_last_ff;

endmodule

FILE: hdl/spectrum_bin_db_smooth_peak_unit.sv
// Top level of the spectrum bin dB smoothing / peak-hold block: register port and wiring.
// Depends on dbp_pkg, dbp_front, dbp_queue and dbp_back.
//
// Usage:
//  - req channel carries one FFT bin per transfer: bin number and Q12.20 magnitude.
//  - rsp channel returns one transfer per bin: instant, smoothed and peak levels
//    in signed dB (DB_FRAC_BITS fraction bits); tlast marks the final bin of a frame.
//  - csr is an APB-style register port, registers at byte address 4*index.
//  - Throughput: one bin per clock while rsp_tready is high and no clearing pass
//    runs. Path from req transfer to rsp valid: 2 normalize + 16 squaring stages
//    of the log units, 4 scaling/tilt stages, queue, store update stage, result register.
//  - Reset, and any write to fft_order, start a clearing pass that fills both
//    stores with floor_db, one entry per cycle over all MAX_BINS entries (2048 by default).
//    req_tready stays low during the pass; register writes are still taken.
//  - When the receiver stalls, the result register holds, the store update
//    stage waits, the queue fills, and then the front pipeline freezes and
//    drops req_tready. Nothing is lost; flow resumes at full rate.
//  - Write registers only while no bin is in flight.
module spectrum_bin_db_smooth_peak_unit #(
   parameter int MAX_BINS     = dbp_pkg::DEF_MAX_BINS,
   parameter int DB_FRAC_BITS = dbp_pkg::DEF_DB_FRAC
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [10:0] bin_number, [42:11] magnitude, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [10:0] bin_out, [26:11] level_db, [42:27] smoothed_db,
                                    // [58:43] held_peak_db, rest zero
   output logic        rsp_tlast,   // last_bin
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dbp_pkg::*;

   logic [3:0]  fft_order_ff;
   logic [17:0] sample_rate_ff;
   logic [11:0] tilt_slope_ff;
   logic [15:0] smooth_coeff_ff;
   logic [15:0] floor_db_ff;
   logic [15:0] ceiling_db_ff;
   logic [11:0] peak_decay_ff;

   logic       wr;
   logic [2:0] idx;
   logic       fill_start;
   logic       clearing;

   front_cfg_type fcfg;
   back_cfg_type  bcfg;

   logic       q_push, q_full, q_pop, q_nonempty;
   q_item_type q_in, q_out;

   logic [BIN_W-1:0] o_bin;
   logic [LVL_W-1:0] o_lvl, o_s, o_p;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign fill_start = wr && (idx == REG_FFT_ORDER);

   // register file; writes beyond the map are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         fft_order_ff    <= RST_FFT_ORDER;
         sample_rate_ff  <= RST_SAMPLE_RATE;
         tilt_slope_ff   <= RST_TILT_SLOPE;
         smooth_coeff_ff <= RST_SMOOTH_COEFF;
         floor_db_ff     <= RST_FLOOR_DB;
         ceiling_db_ff   <= RST_CEILING_DB;
         peak_decay_ff   <= RST_PEAK_DECAY;
      end else if (wr) begin
         case (idx)
            REG_FFT_ORDER:    fft_order_ff    <= csr_pwdata[3:0];
            REG_SAMPLE_RATE:  sample_rate_ff  <= csr_pwdata[17:0];
            REG_TILT_SLOPE:   tilt_slope_ff   <= csr_pwdata[11:0];
            REG_SMOOTH_COEFF: smooth_coeff_ff <= csr_pwdata[15:0];
            REG_FLOOR_DB:     floor_db_ff     <= csr_pwdata[15:0];
            REG_CEILING_DB:   ceiling_db_ff   <= csr_pwdata[15:0];
            REG_PEAK_DECAY:   peak_decay_ff   <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_FFT_ORDER:    csr_prdata = 32'(fft_order_ff);
         REG_SAMPLE_RATE:  csr_prdata = 32'(sample_rate_ff);
         REG_TILT_SLOPE:   csr_prdata = 32'(tilt_slope_ff);
         REG_SMOOTH_COEFF: csr_prdata = 32'(smooth_coeff_ff);
         REG_FLOOR_DB:     csr_prdata = 32'(floor_db_ff);
         REG_CEILING_DB:   csr_prdata = 32'(ceiling_db_ff);
         REG_PEAK_DECAY:   csr_prdata = 32'(peak_decay_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // order outside 11..12 acts as the nearest end
   always_comb begin
      fcfg.order12     = (fft_order_ff >= 4'd12);
      fcfg.sample_rate = sample_rate_ff;
      fcfg.tilt_slope  = tilt_slope_ff;
      fcfg.floor_db    = floor_db_ff;
      fcfg.ceiling_db  = ceiling_db_ff;
      bcfg.smooth_coeff = smooth_coeff_ff;
      bcfg.floor_db     = floor_db_ff;
      bcfg.peak_decay   = peak_decay_ff;
   end

   dbp_front #(.DB_FRAC_BITS(DB_FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_bin   (req_tdata[10:0]),
      .in_mag   (req_tdata[42:11]),
      .block_in (clearing),
      .cfg      (fcfg),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (q_in)
   );

   dbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .din      (q_in),
      .full     (q_full),
      .pop      (q_pop),
      .nonempty (q_nonempty),
      .dout     (q_out)
   );

   dbp_back #(.MAX_BINS(MAX_BINS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_nonempty),
      .q_item     (q_out),
      .q_pop      (q_pop),
      .cfg        (bcfg),
      .fill_start (fill_start),
      .clearing   (clearing),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_bin    (o_bin),
      .out_level  (o_lvl),
      .out_smooth (o_s),
      .out_peak   (o_p),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'b00000, o_p, o_s, o_lvl, o_bin};

endmodule
